// File: src/scsmt_pkg.sv
`timescale 1ns / 1ps

package scsmt_pkg;

	localparam int ICON_SIDE = 128;
	localparam int COORD_W   = $clog2(ICON_SIDE);
	localparam int OUT_W     = COORD_W + 1;
	localparam int FRAC      = COORD_W;
	localparam int TILE_W    = 3;
	localparam int IDX_W     = 2 * COORD_W;

	localparam int DIM_W     = 13;
	localparam int POS_W     = 12;
	localparam int MAX_DIM   = 4096;
	localparam int MIN_SIDE  = (ICON_SIDE + 7) / 8;
	localparam int DIM_RESET = 128;

	// upscale is bounded, so one axis never yields more than this many outputs
	localparam int RUN_MAX   = ICON_SIDE / MIN_SIDE;
	localparam int RUN_W     = $clog2(RUN_MAX + 1);
	localparam int K_W       = $clog2(RUN_MAX);
	localparam int ACC_W     = $clog2((ICON_SIDE + RUN_MAX) * MAX_DIM + 1);

	localparam int IN_W      = 24;
	localparam int RGB_W     = 16;
	localparam int TDATA_W   = 32;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RECALC,
		ST_CALC,
		ST_EMIT
	} scsmt_state_t;

	typedef struct packed {
		logic take;
		logic recalc;
		logic calc;
		logic emit;
	} scsmt_cmd_t;

	typedef struct packed {
		logic stale;
		logic recalc_done;
		logic emit_any;
		logic emit_last;
		logic out_free;
	} scsmt_sts_t;

	// 8x8 tiles in raster order, Morton order inside a tile (x on even bits)
	function automatic logic [IDX_W-1:0] tile_index(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y);
		return {y[COORD_W-1:TILE_W], x[COORD_W-1:TILE_W],
			y[2], x[2], y[1], x[1], y[0], x[0]};
	endfunction

	function automatic logic [RGB_W-1:0] to_rgb565(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

// File: src/scsmt_ctrl.sv
`timescale 1ns / 1ps

module scsmt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  scsmt_pkg::scsmt_sts_t sts,
	output scsmt_pkg::scsmt_cmd_t cmd
);

	scsmt_pkg::scsmt_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scsmt_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			scsmt_pkg::ST_IDLE: begin
				if (sts.stale) begin
					state_nxt = scsmt_pkg::ST_RECALC;
				end else if (s_tvalid) begin
					state_nxt = scsmt_pkg::ST_CALC;
				end
			end
			scsmt_pkg::ST_RECALC: begin
				if (sts.recalc_done) begin
					state_nxt = scsmt_pkg::ST_IDLE;
				end
			end
			scsmt_pkg::ST_CALC: begin
				if (sts.emit_any) begin
					state_nxt = scsmt_pkg::ST_EMIT;
				end else begin
					state_nxt = scsmt_pkg::ST_IDLE;
				end
			end
			scsmt_pkg::ST_EMIT: begin
				if (sts.out_free && sts.emit_last) begin
					state_nxt = scsmt_pkg::ST_IDLE;
				end
			end
			default: state_nxt = scsmt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			scsmt_pkg::ST_IDLE: begin
				s_tready = !sts.stale;
				cmd.take = !sts.stale && s_tvalid;
			end
			scsmt_pkg::ST_RECALC: cmd.recalc = 1'b1;
			scsmt_pkg::ST_CALC:   cmd.calc   = 1'b1;
			scsmt_pkg::ST_EMIT:   cmd.emit   = sts.out_free;
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

// File: src/scsmt_dp.sv
`timescale 1ns / 1ps

module scsmt_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [scsmt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [scsmt_pkg::DIM_W-1:0]          cfg_data,
	input  logic [scsmt_pkg::IN_W-1:0]           in_rgb,
	input  logic                                 in_first,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic [scsmt_pkg::IDX_W-1:0]          out_idx,
	output logic [scsmt_pkg::RGB_W-1:0]          out_rgb,
	output logic                                 out_last,
	input  scsmt_pkg::scsmt_cmd_t                cmd,
	output scsmt_pkg::scsmt_sts_t                sts
);

	localparam int DW = scsmt_pkg::DIM_W;
	localparam int PW = scsmt_pkg::POS_W;
	localparam int AW = scsmt_pkg::ACC_W;
	localparam int OW = scsmt_pkg::OUT_W;
	localparam int RW = scsmt_pkg::RUN_W;
	localparam int KW = scsmt_pkg::K_W;
	localparam int RM = scsmt_pkg::RUN_MAX;
	localparam int FR = scsmt_pkg::FRAC;
	localparam int CW = scsmt_pkg::COORD_W;

	// configuration
	logic [DW-1:0] width_q, height_q;
	logic [DW-1:0] w_c, h_c, side;

	// scan position and first output row/column of the next source pixel
	logic [PW-1:0] col_q, row_q;
	logic [OW-1:0] cx_q, ry_q;
	logic [AW-1:0] cxa_q, rya_q;
	logic          stale_q;

	// accepted pixel
	logic [scsmt_pkg::RGB_W-1:0] rgb_s1;
	logic [PW-1:0] sx_s1, sy_s1;
	logic [OW-1:0] xs_s1, ys_s1;
	logic [AW-1:0] xa_s1, ya_s1;

	// replication counters
	logic [RW-1:0] nx_q, ny_q;
	logic [KW-1:0] kx_q, ky_q;

	logic          out_valid_q, out_last_q;
	logic [scsmt_pkg::IDX_W-1:0] out_idx_q;
	logic [scsmt_pkg::RGB_W-1:0] out_rgb_q;

	logic          col_wrap, row_wrap;
	logic [AW-1:0] sum_x [RM+1];
	logic [AW-1:0] sum_y [RM+1];
	logic [RM-1:0] hit_x, hit_y;
	logic [RW-1:0] nx, ny;
	logic          run_x, run_y;
	logic [DW-1:0] sx_inc, sy_inc;
	logic          end_col, end_row;
	logic          step_x, step_y;
	logic          kx_end, ky_end;
	logic [OW-1:0] x_cur, y_cur;
	logic          out_free;

	always_comb begin
		if (width_q < DW'(scsmt_pkg::MIN_SIDE)) begin
			w_c = DW'(scsmt_pkg::MIN_SIDE);
		end else if (width_q > DW'(scsmt_pkg::MAX_DIM)) begin
			w_c = DW'(scsmt_pkg::MAX_DIM);
		end else begin
			w_c = width_q;
		end
		if (height_q < DW'(scsmt_pkg::MIN_SIDE)) begin
			h_c = DW'(scsmt_pkg::MIN_SIDE);
		end else if (height_q > DW'(scsmt_pkg::MAX_DIM)) begin
			h_c = DW'(scsmt_pkg::MAX_DIM);
		end else begin
			h_c = height_q;
		end
		side = (w_c < h_c) ? w_c : h_c;
	end

	assign col_wrap = in_first || ({1'b0, col_q} >= w_c);
	assign row_wrap = in_first || ({1'b0, row_q} >= h_c);

	// candidate outputs k = 0..RUN_MAX-1 along each axis, taken as a prefix
	always_comb begin
		for (int k = 0; k <= RM; k++) begin
			sum_x[k] = xa_s1 + AW'(side) * AW'(k);
			sum_y[k] = ya_s1 + AW'(side) * AW'(k);
		end
		for (int k = 0; k < RM; k++) begin
			hit_x[k] = (sum_x[k][AW-1:FR] == (AW-FR)'(sx_s1)) &&
				(({1'b0, xs_s1} + (OW+1)'(k)) < (OW+1)'(scsmt_pkg::ICON_SIDE));
			hit_y[k] = (sum_y[k][AW-1:FR] == (AW-FR)'(sy_s1)) &&
				(({1'b0, ys_s1} + (OW+1)'(k)) < (OW+1)'(scsmt_pkg::ICON_SIDE));
		end
	end

	always_comb begin
		nx    = '0;
		ny    = '0;
		run_x = 1'b1;
		run_y = 1'b1;
		for (int k = 0; k < RM; k++) begin
			if (run_x && hit_x[k]) begin
				nx = nx + RW'(1);
			end else begin
				run_x = 1'b0;
			end
			if (run_y && hit_y[k]) begin
				ny = ny + RW'(1);
			end else begin
				run_y = 1'b0;
			end
		end
	end

	assign sx_inc  = {1'b0, sx_s1} + DW'(1);
	assign sy_inc  = {1'b0, sy_s1} + DW'(1);
	assign end_col = sx_inc >= w_c;
	assign end_row = sy_inc >= h_c;

	// after a geometry change, walk the trackers up to the current position
	assign step_x = (cx_q < OW'(scsmt_pkg::ICON_SIDE)) && (cxa_q < (AW'(col_q) << FR));
	assign step_y = (ry_q < OW'(scsmt_pkg::ICON_SIDE)) && (rya_q < (AW'(row_q) << FR));

	assign kx_end = ({1'b0, kx_q} == nx_q - RW'(1));
	assign ky_end = ({1'b0, ky_q} == ny_q - RW'(1));
	assign x_cur  = xs_s1 + OW'(kx_q);
	assign y_cur  = ys_s1 + OW'(ky_q);

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		sts.stale       = stale_q;
		sts.recalc_done = !step_x && !step_y;
		sts.emit_any    = ({1'b0, sx_s1} < side) && ({1'b0, sy_s1} < side) &&
			(nx != '0) && (ny != '0);
		sts.emit_last   = kx_end && ky_end;
		sts.out_free    = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DW'(scsmt_pkg::DIM_RESET);
			height_q <= DW'(scsmt_pkg::DIM_RESET);
			col_q    <= '0;
			row_q    <= '0;
			cx_q     <= '0;
			ry_q     <= '0;
			cxa_q    <= '0;
			rya_q    <= '0;
			stale_q  <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == scsmt_pkg::CFG_SRC_WIDTH) begin
				width_q <= cfg_data;
			end else if (cfg_index == scsmt_pkg::CFG_SRC_HEIGHT) begin
				height_q <= cfg_data;
			end
			cx_q    <= '0;
			ry_q    <= '0;
			cxa_q   <= '0;
			rya_q   <= '0;
			stale_q <= 1'b1;
		end else if (cmd.recalc) begin
			if (step_x) begin
				cx_q  <= cx_q + OW'(1);
				cxa_q <= cxa_q + AW'(side);
			end
			if (step_y) begin
				ry_q  <= ry_q + OW'(1);
				rya_q <= rya_q + AW'(side);
			end
			if (!step_x && !step_y) begin
				stale_q <= 1'b0;
			end
		end else if (cmd.calc) begin
			if (end_col) begin
				col_q <= '0;
				cx_q  <= '0;
				cxa_q <= '0;
				if (end_row) begin
					row_q <= '0;
					ry_q  <= '0;
					rya_q <= '0;
				end else begin
					row_q <= sy_inc[PW-1:0];
					ry_q  <= ys_s1 + OW'(ny);
					rya_q <= sum_y[ny];
				end
			end else begin
				col_q <= sx_inc[PW-1:0];
				cx_q  <= xs_s1 + OW'(nx);
				cxa_q <= sum_x[nx];
				row_q <= sy_s1;
				ry_q  <= ys_s1;
				rya_q <= ya_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			rgb_s1 <= scsmt_pkg::to_rgb565(in_rgb[7:0], in_rgb[15:8], in_rgb[23:16]);
			sx_s1  <= col_wrap ? '0 : col_q;
			xs_s1  <= col_wrap ? '0 : cx_q;
			xa_s1  <= col_wrap ? '0 : cxa_q;
			sy_s1  <= row_wrap ? '0 : row_q;
			ys_s1  <= row_wrap ? '0 : ry_q;
			ya_s1  <= row_wrap ? '0 : rya_q;
		end
		if (cmd.calc) begin
			nx_q <= nx;
			ny_q <= ny;
			kx_q <= '0;
			ky_q <= '0;
		end else if (cmd.emit) begin
			if (kx_end) begin
				kx_q <= '0;
				ky_q <= ky_q + KW'(1);
			end else begin
				kx_q <= kx_q + KW'(1);
			end
		end
		if (cmd.emit) begin
			out_idx_q  <= scsmt_pkg::tile_index(x_cur[CW-1:0], y_cur[CW-1:0]);
			out_rgb_q  <= rgb_s1;
			out_last_q <= kx_end && ky_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_idx   = out_idx_q;
	assign out_rgb   = out_rgb_q;
	assign out_last  = out_last_q;

endmodule

// File: src/square_crop_scale_morton_tile_top.sv
`timescale 1ns / 1ps

// Square crop, nearest-neighbor scale to 128x128 and Morton tiling of an RGB888 pixel
// stream. Pixels arrive in raster order over a src_width x src_height frame; the
// top-left square of side min(width, height) is mapped onto the output grid, and each
// pixel in it yields one item per output pixel that takes it (row-major, 0 to 64 items,
// tlast on the final one) carrying its RGB565 value and its word index in 8x8
// Morton-ordered tiles. Dimensions saturate to 16..4096. tuser marks the first pixel
// of a frame; frames that follow each other need no mark. A pixel is accepted, then
// its range is calculated, then its items follow at one per cycle while the output
// does not stall; the output register lets the next pixel be accepted while the
// last item waits. After any configuration write the row and column trackers are
// rebuilt by stepping once per output coordinate, with s_tready low meanwhile.

module square_crop_scale_morton_tile_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [scsmt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [scsmt_pkg::DIM_W-1:0]         cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [scsmt_pkg::IN_W-1:0]          s_tdata,  // red, green, blue
	input  logic                                s_tuser,  // frame_start
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [scsmt_pkg::TDATA_W-1:0]       m_tdata,  // tile_index, pixel_rgb565, pad
	output logic                                m_tlast
);

	scsmt_pkg::scsmt_cmd_t cmd;
	scsmt_pkg::scsmt_sts_t sts;
	logic [scsmt_pkg::IDX_W-1:0] out_idx;
	logic [scsmt_pkg::RGB_W-1:0] out_rgb;

	scsmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	scsmt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_rgb    (s_tdata),
		.in_first  (s_tuser),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_idx   (out_idx),
		.out_rgb   (out_rgb),
		.out_last  (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

	assign m_tdata = {(scsmt_pkg::TDATA_W - scsmt_pkg::IDX_W - scsmt_pkg::RGB_W)'(0),
		out_rgb, out_idx};

endmodule
